// ===== hdl/packet_framer_with_fcs9_macros.svh =====
// ---------------------------------------------------------------------------
// packet_framer_with_fcs9_macros.svh
// Assertion macros for the frame builder; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef PACKET_FRAMER_WITH_FCS9_MACROS_SVH
`define PACKET_FRAMER_WITH_FCS9_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PFCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pfcs assertion failed");
// next-cycle implication
`define PFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pfcs assertion failed");
`else
`define PFCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/pfcs_pkg.sv =====
// ---------------------------------------------------------------------------
// pfcs_pkg
// Shared types, constants and the 9-bit check update for the frame builder.
// ---------------------------------------------------------------------------
package pfcs_pkg;

	localparam int CHECK_W  = 9;
	localparam int LEN_W    = 5;
	localparam int CMD_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;

	localparam logic [CHECK_W-1:0] CHECK_FEEDBACK = 9'h100;

	// input kinds carried on tuser
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_PAYLOAD = 1'b1;

	// one queued unit of work: up to two plain bytes, then optional check bytes
	typedef struct packed {
		logic [BYTE_W-1:0]  byte_a;
		logic [BYTE_W-1:0]  byte_b;
		logic               two_bytes;
		logic               close;
		logic               err;
		logic [CHECK_W-1:0] check;
	} job_t;

	function automatic logic [CHECK_W-1:0] check_byte(
		input logic [CHECK_W-1:0] cur,
		input logic [BYTE_W-1:0]  data
	);
		logic [CHECK_W-1:0] c;
		c = cur ^ {1'b0, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CHECK_FEEDBACK;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/pfcs_front.sv =====
// ---------------------------------------------------------------------------
// pfcs_front
// Takes input items, tracks frame state and the check value, queues jobs.
// ---------------------------------------------------------------------------
module pfcs_front #(
	parameter int MAX_PAYLOAD = 31
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           action,
	input  logic [pfcs_pkg::CMD_W-1:0]     command,
	input  logic [pfcs_pkg::LEN_W-1:0]     payload_length,
	input  logic [pfcs_pkg::BYTE_W-1:0]    payload_byte,
	output pfcs_pkg::job_t                 job
);
	import pfcs_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

	logic [CHECK_W-1:0] check_q, check_n;
	logic [LEN_W-1:0]   remain_q, remain_n;
	logic               open_q, open_n;

	logic [LEN_W-1:0]   len_sat;
	logic [BYTE_W-1:0]  hdr0, hdr1;

	always_comb begin
		len_sat = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
		hdr0    = {len_sat[3:0], command};
		hdr1    = {7'b0, len_sat[4]};

		check_n  = check_q;
		remain_n = remain_q;
		open_n   = open_q;

		job.byte_a    = '0;
		job.byte_b    = hdr1;
		job.two_bytes = 1'b0;
		job.close     = 1'b0;
		job.err       = 1'b0;

		if (action == ACT_START) begin
			check_n       = check_byte(check_byte('0, hdr0), hdr1);
			remain_n      = len_sat;
			open_n        = (len_sat != '0);
			job.byte_a    = hdr0;
			job.two_bytes = 1'b1;
			job.close     = (len_sat == '0);
		end else if (open_q) begin
			check_n    = check_byte(check_q, payload_byte);
			remain_n   = remain_q - LEN_W'(1);
			open_n     = (remain_n != '0);
			job.byte_a = payload_byte;
			job.close  = (remain_n == '0);
		end else begin
			job.err = 1'b1;
		end
		job.check = check_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q  <= '0;
			remain_q <= '0;
			open_q   <= 1'b0;
		end else if (accept) begin
			check_q  <= check_n;
			remain_q <= remain_n;
			open_q   <= open_n;
		end
	end

endmodule

// ===== hdl/pfcs_fifo.sv =====
// ---------------------------------------------------------------------------
// pfcs_fifo
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module pfcs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfcs_pkg::job_t wr_job,
	input  logic           pop,
	output pfcs_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);
	import pfcs_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== hdl/pfcs_back.sv =====
// ---------------------------------------------------------------------------
// pfcs_back
// Expands each job into its output bytes, one per cycle while m_tready is high.
// ---------------------------------------------------------------------------
module pfcs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfcs_pkg::job_t              q_job,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pfcs_pkg::BYTE_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);
	import pfcs_pkg::*;

	job_t       cur_q;
	logic       cur_vld_q;
	logic [1:0] step_q;

	logic [1:0] plain_last, last_step;
	logic       at_last;

	always_comb begin
		plain_last = {1'b0, cur_q.two_bytes};
		last_step  = plain_last + (cur_q.close ? 2'd2 : 2'd0);
		at_last    = (step_q == last_step);

		if (step_q <= plain_last) begin
			m_tdata = step_q[0] ? cur_q.byte_b : cur_q.byte_a;
		end else if (step_q == plain_last + 2'd1) begin
			m_tdata = cur_q.check[7:0];
		end else begin
			m_tdata = {7'b0, cur_q.check[8]};
		end
		m_tlast  = cur_q.close && at_last;
		m_tuser  = cur_q.err;
		m_tvalid = cur_vld_q;
		q_pop    = !q_empty && (!cur_vld_q || (m_tready && at_last));
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			step_q    <= '0;
		end else if (q_pop) begin
			cur_vld_q <= 1'b1;
			step_q    <= '0;
		end else if (cur_vld_q && m_tready) begin
			if (at_last) begin
				cur_vld_q <= 1'b0;
				step_q    <= '0;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

endmodule

// ===== hdl/packet_framer_with_fcs9.sv =====
// Path: an accepted item goes into the job queue, then into the back end's job register.
// Throughput: one input item per cycle while the queue is not full; output one
// byte per cycle while m_tready is high, set by the back end, so a start item
// yields two or four bytes and a closing payload item three; a four-job queue absorbs the difference.
// Reset: arst_n clears frame state, check value, queue and output valid at once.
// ---------------------------------------------------------------------------
// packet_framer_with_fcs9
// Frame builder: header, payload and a 9-bit frame check sequence.
// ---------------------------------------------------------------------------
`include "packet_framer_with_fcs9_macros.svh"

module packet_framer_with_fcs9 #(
	parameter int MAX_PAYLOAD = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [3:0] command, [8:4] payload_length,
	                              // [16:9] payload_byte, [23:17] zero
	input  logic        s_tuser,  // [0] action: 0 start, 1 payload
	// output items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast,  // frame_end
	output logic        m_tuser   // [0] error
);
	import pfcs_pkg::*;

	job_t front_job, q_job;
	logic q_full, q_empty, q_pop;
	logic s_accept;

	// the queue gives back pressure; front state moves only on accept
	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	pfcs_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (s_accept),
		.action        (s_tuser),
		.command       (s_tdata[3:0]),
		.payload_length(s_tdata[8:4]),
		.payload_byte  (s_tdata[16:9]),
		.job           (front_job)
	);

	pfcs_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (s_accept),
		.wr_job(front_job),
		.pop   (q_pop),
		.rd_job(q_job),
		.full  (q_full),
		.empty (q_empty)
	);

	// back end: header bytes, payload byte, then check low byte and bit 8
	pfcs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_job   (q_job),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// an accepted item always leaves a queued job behind
	`PFCS_ASSERT_NEXT(a_push_fills, clk, arst_n, s_accept, !q_empty)
	// an idle back end picks up a waiting job in the next cycle
	`PFCS_ASSERT_NEXT(a_back_loads, clk, arst_n, !q_empty && !m_tvalid, m_tvalid)
	// frame end never rides on an error item
	`PFCS_ASSERT_IMPL(a_end_not_err, clk, arst_n, m_tvalid && m_tlast, !m_tuser)

endmodule

// ===== tb/sv/packet_framer_with_fcs9_tb.sv =====
// ---------------------------------------------------------------------------
// packet_framer_with_fcs9_tb
// Self-checking bench for the frame builder. Start and payload items go in
// over the slave stream; every output byte is checked against a predicted
// byte. Covers headers, payload bytes, the 9-bit check bytes, abandoned
// frames and payload items that arrive with no open frame.
// ---------------------------------------------------------------------------
module packet_framer_with_fcs9_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfcs_pkg::*;

	// one output item as the block should deliver it
	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              frame_end;
		logic              error;
	} frame_byte_t;

	// Predicts the byte stream and compares what comes out, in order.
	class frame_scoreboard;
		frame_byte_t        expected_bytes[$];
		logic [CHECK_W-1:0] fcs;
		logic [LEN_W-1:0]   remaining;
		bit                 open;
		int                 mismatches;
		int                 results_seen;
		int                 items_noted;
		int                 frames_closed;
		int                 frames_abandoned;
		int                 stray_payloads;

		function new();
			fcs = '0;
			remaining = '0;
			open = 1'b0;
			mismatches = 0;
			results_seen = 0;
			items_noted = 0;
			frames_closed = 0;
			frames_abandoned = 0;
			stray_payloads = 0;
		endfunction

		// XOR the byte in, then eight right shifts with the dropped bit fed
		// back into bit 8: that is eight right rotations of the 9-bit value,
		// which is the same as one left rotation.
		function logic [CHECK_W-1:0] fold_byte(logic [CHECK_W-1:0] acc,
			logic [BYTE_W-1:0] b);
			logic [CHECK_W-1:0] t;
			t = acc ^ {1'b0, b};
			return {t[CHECK_W-2:0], t[CHECK_W-1]};
		endfunction

		function void push(logic [BYTE_W-1:0] b, logic fe, logic er);
			frame_byte_t e;
			e.out_byte = b;
			e.frame_end = fe;
			e.error = er;
			expected_bytes.push_back(e);
		endfunction

		// check low byte, then check bit 8 flagged as end of frame
		function void close_frame();
			push(fcs[7:0], 1'b0, 1'b0);
			push({7'd0, fcs[8]}, 1'b1, 1'b0);
			open = 1'b0;
			remaining = '0;
			frames_closed++;
		endfunction

		function void note_item(logic act, logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
			logic [BYTE_W-1:0] data);
			logic [BYTE_W-1:0] hdr_lo;
			logic [BYTE_W-1:0] hdr_hi;
			items_noted++;
			if (act == ACT_START) begin
				if (open) begin
					frames_abandoned++;
				end
				// a 5-bit length never exceeds the 31-byte maximum: no clamp needed
				hdr_lo = {len[3:0], cmd};
				hdr_hi = {7'd0, len[4]};
				fcs = fold_byte(fold_byte('0, hdr_lo), hdr_hi);
				push(hdr_lo, 1'b0, 1'b0);
				push(hdr_hi, 1'b0, 1'b0);
				open = 1'b1;
				remaining = len;
				if (len == 0) begin
					close_frame();
				end
			end else if (!open) begin
				// dropped byte, single error item, state untouched
				stray_payloads++;
				push(8'h00, 1'b0, 1'b1);
			end else begin
				fcs = fold_byte(fcs, data);
				push(data, 1'b0, 1'b0);
				if (remaining != 0) begin
					remaining--;
				end
				if (remaining == 0) begin
					close_frame();
				end
			end
		endfunction

		function void check_output(logic [BYTE_W-1:0] b, logic fe, logic er);
			frame_byte_t e;
			results_seen++;
			if (expected_bytes.size() == 0) begin
				$error("unexpected output item: out_byte 0x%02h frame_end %0b error %0b",
					b, fe, er);
				mismatches++;
				return;
			end
			e = expected_bytes.pop_front();
			if (b !== e.out_byte) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", e.out_byte, b);
				mismatches++;
			end
			if (fe !== e.frame_end) begin
				$error("frame_end: expected %0b, got %0b", e.frame_end, fe);
				mismatches++;
			end
			if (er !== e.error) begin
				$error("error: expected %0b, got %0b", e.error, er);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [3:0] command, [8:4] payload_length,
	                        // [16:9] payload_byte, [23:17] zero
	logic        s_tuser;   // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] out_byte
	logic        m_tlast;   // frame_end
	logic        m_tuser;   // [0] error

	// both sides stop idling while this is set
	bit calm;

	frame_scoreboard sb = new();

	packet_framer_with_fcs9 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Present one item, with a random gap ahead of it, and hold it until taken.
	// s_tready is sampled at the falling edge, where it is settled; the item
	// moves at the following rising edge.
	task automatic send_item(input logic act, input logic [CMD_W-1:0] cmd,
		input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
		bit taken;
		while (!calm && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, data, len, cmd};
		do begin
			@(negedge clk);
			taken = s_tready;
			if (taken) begin
				sb.note_item(act, cmd, len, data);
			end
			@(posedge clk);
		end while (!taken);
	endtask

	// unused fields of a start item carry random noise
	task automatic send_start(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len);
		send_item(ACT_START, cmd, len, BYTE_W'($urandom));
	endtask

	// unused fields of a payload item carry random noise
	task automatic send_payload(input logic [BYTE_W-1:0] data);
		send_item(ACT_PAYLOAD, CMD_W'($urandom), LEN_W'($urandom), data);
	endtask

	// hold off the sender until every predicted byte has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 32);
		end
	end

	// output item taken at the next rising edge; values are stable here
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_output(m_tdata, m_tlast, m_tuser);
		end
	end

	initial begin
		int               pick;
		int               cut;
		logic [LEN_W-1:0] len;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		calm     = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// --- directed part ---
		send_payload(8'hFF);          // payload straight after reset: error item
		send_start(4'h0, 5'd0);       // empty frame, check bytes right after header
		send_start(4'hF, 5'd31);      // longest length, all command and length bits set
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'hA5);
		send_start(4'h5, 5'd2);       // abandons the open 31-byte frame
		send_payload(8'h3C);
		send_payload(8'hC3);          // closes the frame
		send_payload(8'h01);          // no frame open: error item
		send_start(4'hA, 5'd16);      // length bit 4 alone in the second header byte
		send_payload(8'h80);
		send_start(4'h9, 5'd1);       // abandon again
		send_payload(8'hFF);
		send_start(4'hF, 5'd0);
		send_payload(8'h00);          // error after an empty frame
		send_start(4'h0, 5'd15);      // length bits 3..0 all set, bit 4 clear
		send_payload(8'h7E);
		send_start(4'h3, 5'd1);
		send_payload(8'h00);

		// sender holds off until the output has fully caught up
		wait_drained();

		// --- random part: mostly well-formed frames, some cut short, some strays ---
		while (sb.items_noted < 220) begin
			calm = (sb.items_noted >= 90 && sb.items_noted < 140);
			pick = $urandom_range(99);
			if (pick < 8) begin
				len = 5'd31;
			end else if (pick < 16) begin
				len = LEN_W'($urandom_range(16, 30));
			end else begin
				len = LEN_W'($urandom_range(0, 6));
			end
			cut = ($urandom_range(99) < 12) ? $urandom_range(0, len) : len;
			send_start(CMD_W'($urandom), len);
			for (int k = 0; k < cut; k++) begin
				send_payload(BYTE_W'($urandom));
			end
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 2)) send_payload(BYTE_W'($urandom));
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then keep watching to catch anything extra
		while (sb.expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Ran %0d input items: %0d frames closed, %0d abandoned, %0d stray payloads.",
			sb.items_noted, sb.frames_closed, sb.frames_abandoned, sb.stray_payloads);
		$display("Checked %0d output bytes, %0d field mismatches.",
			sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
